FILE: sv/psched_pkg.sv
package psched_pkg;

  // Table geometry
  localparam int MAX_PROCS = 64;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int TIME_W    = 32;

  // Opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_LOADED    = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_BAD_BURST = 3'd2;
  localparam logic [2:0] ST_RAN       = 3'd3;
  localparam logic [2:0] ST_IDLE      = 3'd4;

  // One process table entry as held in memory
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [9:0]  prio;
  } entry_t;

endpackage

FILE: sv/psched_ram.sv
module psched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/preemptive_priority_scheduler_core.sv
// Channel   Ports                                        Handshake
// input     in_opcode .. in_priority_req (five ports)    start && !busy
// result    out_status .. out_unfinished_count (seven)   out_strobe, one cycle
//
// A load strobes its result in the cycle after acceptance and never raises busy.
// A tick reads one entry a cycle through the single table read port, then uses a drain
// state for the last read and a write-back state; its strobe is registered in write back
// (entered straight from idle on an empty table), and busy holds until the strobe.
// Synchronous active-low reset clears fill count, time and control; the table memory
// is not cleared, only entries below the fill count are read. The receiver cannot stall.
module preemptive_priority_scheduler_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [7:0]                    in_process_id,
  input  logic [15:0]                   in_arrival_time,
  input  logic [15:0]                   in_burst_time,
  input  logic [9:0]                    in_priority_req,
  output logic                          out_strobe,
  output logic [2:0]                    out_status,
  output logic [7:0]                    out_ran_id,
  output logic                          out_completed,
  output logic [31:0]                   out_completion_time,
  output logic [31:0]                   out_turnaround_time,
  output logic [31:0]                   out_waiting_time,
  output logic [psched_pkg::CNT_W-1:0]  out_unfinished_count
);
  import psched_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_WB} state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   loaded_count_r;
  logic [CNT_W-1:0]   unfinished_r;
  logic [TIME_W-1:0]  time_r;
  logic [IDX_W-1:0]   issue_r;
  logic               rd_vld_r;
  logic               found_r;
  logic [IDX_W-1:0]   best_idx_r;
  entry_t             best_r;

  // Index of the entry whose data the memory returns this cycle
  logic [IDX_W-1:0]   rd_vld_idx;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  entry_t             new_entry;

  logic               accept;
  logic               cand_ready;
  logic               cand_better;
  logic               last_issue;
  logic               finishing;
  logic [TIME_W-1:0]  ct;
  logic [TIME_W-1:0]  tat;
  logic [TIME_W-1:0]  burst_ext;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign new_entry = '{id: in_process_id, arrival: in_arrival_time, burst: in_burst_time,
                       remaining: in_burst_time, prio: in_priority_req};

  // Entry memory write: new load, or write back of the served entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = loaded_count_r[IDX_W-1:0];
    ram_wdata = new_entry;
    if (accept && in_opcode == OP_LOAD && in_burst_time != 16'd0 &&
        loaded_count_r != CNT_W'(MAX_PROCS)) begin
      ram_we = 1'b1;
    end else if (state_r == S_WB && found_r) begin
      ram_we              = 1'b1;
      ram_waddr           = best_idx_r;
      ram_wdata           = best_r;
      ram_wdata.remaining = best_r.remaining - 16'd1;
    end
  end

  psched_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_r),
    .rdata (ram_rdata)
  );

  // Candidate test on the entry returned by the memory
  assign cand_ready  = (ram_rdata.remaining != 16'd0) &&
                       ({16'd0, ram_rdata.arrival} <= time_r);
  assign cand_better = !found_r || (ram_rdata.prio < best_r.prio) ||
                       ((ram_rdata.prio == best_r.prio) &&
                        (ram_rdata.arrival < best_r.arrival));
  assign last_issue  = (CNT_W'(issue_r) == loaded_count_r - CNT_W'(1));

  // Completion figures for the served entry
  assign finishing = found_r && (best_r.remaining == 16'd1);
  assign ct        = (time_r == '1) ? time_r : time_r + TIME_W'(1);
  assign tat       = ct - {16'd0, best_r.arrival};
  assign burst_ext = {16'd0, best_r.burst};

  // Sequencer, counters and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      loaded_count_r <= '0;
      unfinished_r   <= '0;
      time_r         <= '0;
      issue_r        <= '0;
      rd_vld_r       <= 1'b0;
      found_r        <= 1'b0;
      out_strobe     <= 1'b0;
    end else begin
      out_strobe <= 1'b0;

      // Track the best ready entry as data returns from the memory
      if (rd_vld_r && cand_ready && cand_better) begin
        found_r    <= 1'b1;
        best_idx_r <= rd_vld_idx;
        best_r     <= ram_rdata;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_opcode == OP_LOAD) begin
              out_strobe          <= 1'b1;
              out_ran_id          <= '0;
              out_completed       <= 1'b0;
              out_completion_time <= '0;
              out_turnaround_time <= '0;
              out_waiting_time    <= '0;
              out_unfinished_count <= unfinished_r;
              if (in_burst_time == 16'd0) begin
                out_status <= ST_BAD_BURST;
              end else if (loaded_count_r == CNT_W'(MAX_PROCS)) begin
                out_status <= ST_FULL;
              end else begin
                out_status           <= ST_LOADED;
                loaded_count_r       <= loaded_count_r + CNT_W'(1);
                unfinished_r         <= unfinished_r + CNT_W'(1);
                out_unfinished_count <= unfinished_r + CNT_W'(1);
              end
            end else begin
              found_r  <= 1'b0;
              rd_vld_r <= 1'b0;
              issue_r  <= '0;
              state_r  <= (loaded_count_r == '0) ? S_WB : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_vld_r   <= 1'b1;
          rd_vld_idx <= issue_r;
          if (last_issue) begin
            state_r <= S_DRAIN;
          end else begin
            issue_r <= issue_r + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          rd_vld_r <= 1'b0;
          state_r  <= S_WB;
        end
        S_WB: begin
          out_strobe           <= 1'b1;
          out_status           <= found_r ? ST_RAN : ST_IDLE;
          out_ran_id           <= found_r ? best_r.id : 8'd0;
          out_completed        <= finishing;
          out_completion_time  <= finishing ? ct : '0;
          out_turnaround_time  <= finishing ? tat : '0;
          out_waiting_time     <= (finishing && tat >= burst_ext) ? tat - burst_ext : '0;
          out_unfinished_count <= finishing ? unfinished_r - CNT_W'(1) : unfinished_r;
          if (finishing) begin
            unfinished_r <= unfinished_r - CNT_W'(1);
          end
          if (time_r != '1) begin
            time_r <= time_r + TIME_W'(1);
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Unfinished processes never outnumber loaded ones
  a_unfinished_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    unfinished_r <= loaded_count_r)
    else $error("unfinished count exceeds loaded count");

  // Fill count stays within the table
  a_loaded_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_count_r <= CNT_W'(MAX_PROCS))
    else $error("loaded count beyond table depth");

  // Table writes happen only at load acceptance or write back
  a_we_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_WB))
    else $error("table write during scan");

  // A completion is reported only for a process that ran
  a_completed_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_completed) |-> (out_status == ST_RAN))
    else $error("completion without service");

  // Time never goes backward
  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> time_r >= $past(time_r))
    else $error("time counter decreased");
`endif

endmodule

FILE: sim/psched_checker.sv
module psched_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_opcode,
  input  logic [7:0]                    in_process_id,
  input  logic [15:0]                   in_arrival_time,
  input  logic [15:0]                   in_burst_time,
  input  logic [9:0]                    in_priority_req,
  input  logic                          out_strobe,
  input  logic [2:0]                    out_status,
  input  logic [7:0]                    out_ran_id,
  input  logic                          out_completed,
  input  logic [31:0]                   out_completion_time,
  input  logic [31:0]                   out_turnaround_time,
  input  logic [31:0]                   out_waiting_time,
  input  logic [psched_pkg::CNT_W-1:0]  out_unfinished_count,
  output int unsigned                   fail_count,
  output int unsigned                   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import psched_pkg::*;

  typedef struct {
    logic [2:0]       status;
    logic [7:0]       ran_id;
    logic             completed;
    logic [31:0]      completion_time;
    logic [31:0]      turnaround_time;
    logic [31:0]      waiting_time;
    logic [CNT_W-1:0] unfinished;
  } sched_result_t;

  // Shadow copy of the process table and the scheduler clock
  entry_t            proc_table [MAX_PROCS];
  logic              proc_done  [MAX_PROCS];
  int unsigned       fill_count = 0;
  logic [TIME_W-1:0] sched_now = '0;

  sched_result_t     expected_results [$];
  int unsigned       mismatches = 0;
  int unsigned       queued = 0;

  assign fail_count    = mismatches;
  assign pending_count = queued;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Apply one transaction to the shadow table and work out its result
  task automatic schedule_item(input logic op, input logic [7:0] pid,
                               input logic [15:0] arr, input logic [15:0] burst,
                               input logic [9:0] prio, output sched_result_t r);
    int   best;
    int   k;
    logic found;
    r.status          = ST_LOADED;
    r.ran_id          = '0;
    r.completed       = 1'b0;
    r.completion_time = '0;
    r.turnaround_time = '0;
    r.waiting_time    = '0;
    r.unfinished      = '0;
    if (op == OP_LOAD) begin
      // Zero burst is refused ahead of the table-full check
      if (burst == 16'd0) begin
        r.status = ST_BAD_BURST;
      end else if (fill_count >= MAX_PROCS) begin
        r.status = ST_FULL;
      end else begin
        proc_table[fill_count].id        = pid;
        proc_table[fill_count].arrival   = arr;
        proc_table[fill_count].burst     = burst;
        proc_table[fill_count].remaining = burst;
        proc_table[fill_count].prio      = prio;
        proc_done[fill_count]            = 1'b0;
        fill_count++;
        r.status = ST_LOADED;
      end
    end else begin
      // Pick the ready process: lowest priority, then earliest arrival,
      // then earliest load
      found = 1'b0;
      best  = 0;
      for (k = 0; k < fill_count; k++) begin
        if (!proc_done[k] && {16'd0, proc_table[k].arrival} <= sched_now) begin
          if (!found || proc_table[k].prio < proc_table[best].prio ||
              (proc_table[k].prio == proc_table[best].prio &&
               proc_table[k].arrival < proc_table[best].arrival)) begin
            best  = k;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        r.status = ST_IDLE;
      end else begin
        r.status = ST_RAN;
        r.ran_id = proc_table[best].id;
        if (proc_table[best].remaining != 16'd0)
          proc_table[best].remaining--;
        if (proc_table[best].remaining == 16'd0) begin
          proc_done[best]   = 1'b1;
          r.completed       = 1'b1;
          r.completion_time = (sched_now == '1) ? '1 : sched_now + 32'd1;
          r.turnaround_time = r.completion_time - {16'd0, proc_table[best].arrival};
          r.waiting_time    = (r.turnaround_time >= {16'd0, proc_table[best].burst}) ?
                              r.turnaround_time - {16'd0, proc_table[best].burst} : '0;
        end
      end
      // Advance time, saturating at the top
      if (sched_now != '1)
        sched_now++;
    end
    for (k = 0; k < fill_count; k++)
      if (!proc_done[k])
        r.unfinished++;
  endtask

  // Compare each result, then record each new transaction
  always @(posedge clk) begin : monitor
    sched_result_t want;
    sched_result_t fresh;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no transaction pending, status %0d",
                                    out_status));
        end else begin
          want = expected_results.pop_front();
          check_field("status", {29'd0, out_status}, {29'd0, want.status});
          check_field("ran_id", {24'd0, out_ran_id}, {24'd0, want.ran_id});
          check_field("completed", {31'd0, out_completed}, {31'd0, want.completed});
          check_field("completion_time", out_completion_time, want.completion_time);
          check_field("turnaround_time", out_turnaround_time, want.turnaround_time);
          check_field("waiting_time", out_waiting_time, want.waiting_time);
          check_field("unfinished_count", 32'(out_unfinished_count),
                      32'(want.unfinished));
        end
      end
      if (start && !busy) begin
        schedule_item(in_opcode, in_process_id, in_arrival_time, in_burst_time,
                      in_priority_req, fresh);
        expected_results.push_back(fresh);
      end
      queued = expected_results.size();
    end
  end

endmodule

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psched_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_opcode = OP_LOAD;
  logic [7:0]        in_process_id = '0;
  logic [15:0]       in_arrival_time = '0;
  logic [15:0]       in_burst_time = '0;
  logic [9:0]        in_priority_req = '0;
  logic              out_strobe;
  logic [2:0]        out_status;
  logic [7:0]        out_ran_id;
  logic              out_completed;
  logic [31:0]       out_completion_time;
  logic [31:0]       out_turnaround_time;
  logic [31:0]       out_waiting_time;
  logic [CNT_W-1:0]  out_unfinished_count;
  int unsigned       fail_count;
  int unsigned       pending_count;

  // Ticks issued so far, used to aim arrival times near the scheduler clock
  int                tick_count = 0;
  logic              no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  preemptive_priority_scheduler_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_process_id        (in_process_id),
    .in_arrival_time      (in_arrival_time),
    .in_burst_time        (in_burst_time),
    .in_priority_req      (in_priority_req),
    .out_strobe           (out_strobe),
    .out_status           (out_status),
    .out_ran_id           (out_ran_id),
    .out_completed        (out_completed),
    .out_completion_time  (out_completion_time),
    .out_turnaround_time  (out_turnaround_time),
    .out_waiting_time     (out_waiting_time),
    .out_unfinished_count (out_unfinished_count)
  );

  psched_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_process_id        (in_process_id),
    .in_arrival_time      (in_arrival_time),
    .in_burst_time        (in_burst_time),
    .in_priority_req      (in_priority_req),
    .out_strobe           (out_strobe),
    .out_status           (out_status),
    .out_ran_id           (out_ran_id),
    .out_completed        (out_completed),
    .out_completion_time  (out_completion_time),
    .out_turnaround_time  (out_turnaround_time),
    .out_waiting_time     (out_waiting_time),
    .out_unfinished_count (out_unfinished_count),
    .fail_count           (fail_count),
    .pending_count        (pending_count)
  );

  // Drive one transaction at the falling edge and hold it until accepted
  task automatic issue_item(input logic op, input logic [7:0] pid,
                            input logic [15:0] arr, input logic [15:0] burst,
                            input logic [9:0] prio);
    while (!no_gaps && $urandom_range(0, 99) < 15) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_opcode       = op;
    in_process_id   = pid;
    in_arrival_time = arr;
    in_burst_time   = burst;
    in_priority_req = prio;
    start           = 1'b1;
    while (busy)
      @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    if (op == OP_TICK)
      tick_count++;
  endtask

  // Tick with junk on the unused fields
  task automatic issue_tick();
    logic [7:0]  pid;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [9:0]  prio;
    pid   = 8'($urandom);
    arr   = 16'($urandom);
    burst = 16'($urandom);
    prio  = 10'($urandom);
    issue_item(OP_TICK, pid, arr, burst, prio);
  endtask

  initial begin : stimulus
    int          n;
    int          k;
    int          aim;
    int unsigned roll;
    logic [7:0]  pid;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [9:0]  prio;

    // Hold reset, release it at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Idle tick on an empty table
    issue_tick();
    // Zero burst with every other field at its maximum
    issue_item(OP_LOAD, 8'hFF, 16'hFFFF, 16'd0, 10'h3FF);
    // Minimal process that finishes on its first tick
    issue_item(OP_LOAD, 8'h00, 16'h0000, 16'd1, 10'h000);
    issue_tick();
    // Process that never becomes ready, all fields at maximum
    issue_item(OP_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF, 10'h3FF);
    // Equal priority and arrival: load order decides
    issue_item(OP_LOAD, 8'h11, 16'd0, 16'd4, 10'd5);
    issue_item(OP_LOAD, 8'h22, 16'd0, 16'd2, 10'd5);
    // Later arrival with a better priority preempts
    issue_item(OP_LOAD, 8'h33, 16'd3, 16'd2, 10'd2);
    // Equal priority: the earlier arrival wins over the earlier load
    issue_item(OP_LOAD, 8'h55, 16'd6, 16'd1, 10'd7);
    issue_item(OP_LOAD, 8'h66, 16'd5, 16'd1, 10'd7);
    for (k = 0; k < 14; k++)
      issue_tick();

    // Random mix: mostly ticks, some loads, a few zero bursts
    for (n = 0; n < 1450; n++) begin
      no_gaps = (n >= 500 && n < 800);
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        pid  = 8'($urandom);
        arr  = 16'($urandom);
        prio = 10'($urandom);
        issue_item(OP_LOAD, pid, arr, 16'd0, prio);
      end else if (roll < 10) begin
        pid  = 8'($urandom);
        prio = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 7))
                                           : 10'($urandom_range(0, 1023));
        roll = $urandom_range(0, 99);
        if (roll < 70)
          aim = tick_count + $urandom_range(0, 30);
        else if (roll < 85)
          aim = $urandom_range(0, tick_count);
        else
          aim = $urandom_range(0, 65535);
        arr = (aim > 65535) ? 16'hFFFF : 16'(aim);
        // Rare long bursts run at low urgency so they do not starve the rest
        if ($urandom_range(0, 99) < 5) begin
          burst = 16'($urandom_range(1, 65535));
          prio  = 10'($urandom_range(900, 1023));
        end else begin
          burst = 16'($urandom_range(1, 12));
        end
        issue_item(OP_LOAD, pid, arr, burst, prio);
      end else begin
        issue_tick();
      end
    end
    start = 1'b0;

    // Drain outstanding results, then let the longest tick pass
    while (pending_count != 0)
      @(negedge clk);
    repeat (MAX_PROCS + 16) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
